FILE: src/radix_digit_converter_core_macros.svh
// assertion macros for the radix digit converter checker
// no dependencies; included by the checker file only
`ifndef RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RDC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rdc_pkg.sv
// shared types, constants, microcode program and digit helpers of the radix converter
// no dependencies; used by every module of the block
package rdc_pkg;

    localparam int INT_BITS            = 31;
    localparam int FRACTION_BITS       = 24;
    localparam int BASE_BITS           = 5;
    localparam int MAX_FRACTION_DIGITS = 6;
    localparam int DIGIT_BITS          = 4;
    localparam int CHAR_BITS           = 7;

    // divider works on a zero-padded dividend, eight quotient bits per divide step
    localparam int CHUNK_BITS  = 8;
    localparam int CHUNKS      = (INT_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int DIV_BITS    = CHUNKS * CHUNK_BITS;
    localparam int CHUNK_CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int DEPTH_W     = $clog2(INT_BITS + 1);

    localparam logic [BASE_BITS-1:0]  BASE_MIN   = 5'd2;
    localparam logic [BASE_BITS-1:0]  BASE_MAX   = 5'd16;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN  = 4'd10;
    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0]  CHAR_A     = 7'd65;

    typedef struct packed {
        logic [INT_BITS-1:0]      integer_part;
        logic [FRACTION_BITS-1:0] fraction;
        logic [BASE_BITS-1:0]     base;
    } t_in;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] digit_value;
        logic [CHAR_BITS-1:0]  digit_char;
        logic                  is_fraction;
        logic                  last;
    } t_out;

    // datapath operations
    localparam logic [2:0] OP_LOAD      = 3'd0;
    localparam logic [2:0] OP_DIV       = 3'd1;
    localparam logic [2:0] OP_PUSH      = 3'd2;
    localparam logic [2:0] OP_NOP       = 3'd3;
    localparam logic [2:0] OP_EMIT_INT  = 3'd4;
    localparam logic [2:0] OP_EMIT_FRAC = 3'd5;

    // branch conditions
    localparam logic [2:0] C_START      = 3'd0;
    localparam logic [2:0] C_CHUNK_LAST = 3'd1;
    localparam logic [2:0] C_Q_ZERO     = 3'd2;
    localparam logic [2:0] C_ALWAYS     = 3'd3;
    localparam logic [2:0] C_DEPTH_ONE  = 3'd4;
    localparam logic [2:0] C_FRAC_END   = 3'd5;

    // program steps
    localparam logic [2:0] STEP_IDLE      = 3'd0;
    localparam logic [2:0] STEP_DIV       = 3'd1;
    localparam logic [2:0] STEP_PUSH      = 3'd2;
    localparam logic [2:0] STEP_TURN      = 3'd3;
    localparam logic [2:0] STEP_EMIT_INT  = 3'd4;
    localparam logic [2:0] STEP_EMIT_FRAC = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] cond;
        logic [2:0] tgt_t;
        logic [2:0] tgt_f;
    } t_uword;

    typedef struct packed {
        logic [2:0] op;
    } t_ctrl;

    typedef struct packed {
        logic chunk_last;
        logic q_zero;
        logic depth_one;
        logic frac_end;
    } t_status;

    // control store: one word per step
    function automatic t_uword ucode(input logic [2:0] pc);
        t_uword w;
        unique case (pc)
            STEP_IDLE:      w = '{OP_LOAD,      C_START,      STEP_DIV,       STEP_IDLE};
            STEP_DIV:       w = '{OP_DIV,       C_CHUNK_LAST, STEP_PUSH,      STEP_DIV};
            STEP_PUSH:      w = '{OP_PUSH,      C_Q_ZERO,     STEP_TURN,      STEP_DIV};
            STEP_TURN:      w = '{OP_NOP,       C_ALWAYS,     STEP_EMIT_INT,  STEP_EMIT_INT};
            STEP_EMIT_INT:  w = '{OP_EMIT_INT,  C_DEPTH_ONE,  STEP_EMIT_FRAC, STEP_EMIT_INT};
            STEP_EMIT_FRAC: w = '{OP_EMIT_FRAC, C_FRAC_END,   STEP_IDLE,      STEP_EMIT_FRAC};
            default:        w = '{OP_NOP,       C_ALWAYS,     STEP_IDLE,      STEP_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_BITS-1:0] char_of(input logic [DIGIT_BITS-1:0] v);
        logic [CHAR_BITS-1:0] c;
        if (v < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_BITS'(v);
        end else begin
            c = CHAR_A + CHAR_BITS'(v - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

FILE: src/radix_digit_converter_core.sv
// top level of the radix digit converter: microcode sequencer plus datapath
// depends on rdc_pkg, rdc_useq and rdc_datapath
//
//   channel   ports                       transfer
//   input     start, busy, i_item         start high while busy low
//   result    o_strobe, o_result          o_strobe high, one cycle per digit
//
// the divider takes 8 quotient bits a cycle, so each whole-part digit costs one divide
// step per 8-bit chunk of the zero-padded dividend, then a push
// busy stays high until the last digit is issued; results cannot be held off
// synchronous active-low reset returns the sequencer to idle; no clearing pass
module radix_digit_converter_core #(
    parameter int MAX_FRACTION_DIGITS = rdc_pkg::MAX_FRACTION_DIGITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rdc_pkg::t_in  i_item,
    output logic          o_strobe,
    output rdc_pkg::t_out o_result
);

    rdc_pkg::t_ctrl   ctrl;
    rdc_pkg::t_status status;

    rdc_useq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_busy   (busy)
    );

    rdc_datapath #(
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_item),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: src/rdc_useq.sv
// microcode sequencer: step counter, control store lookup and branch selection
// depends on rdc_pkg for the program, op and condition codes
module rdc_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  rdc_pkg::t_status i_status,
    output rdc_pkg::t_ctrl  o_ctrl,
    output logic            o_busy
);

    logic [2:0]      r_pc;
    logic [2:0]      n_pc;
    rdc_pkg::t_uword uw;
    logic            hit;

    assign uw = rdc_pkg::ucode(r_pc);

    always_comb begin
        unique case (uw.cond)
            rdc_pkg::C_START:      hit = i_start;
            rdc_pkg::C_CHUNK_LAST: hit = i_status.chunk_last;
            rdc_pkg::C_Q_ZERO:     hit = i_status.q_zero;
            rdc_pkg::C_ALWAYS:     hit = 1'b1;
            rdc_pkg::C_DEPTH_ONE:  hit = i_status.depth_one;
            rdc_pkg::C_FRAC_END:   hit = i_status.frac_end;
            default:               hit = 1'b1;
        endcase
        n_pc = hit ? uw.tgt_t : uw.tgt_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rdc_pkg::STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op = uw.op;
    assign o_busy    = (r_pc != rdc_pkg::STEP_IDLE);

endmodule

FILE: src/rdc_datapath.sv
// datapath: chunked restoring divider, digit stack memory, fraction multiplier, result register
// depends on rdc_pkg for types, widths and op codes
module rdc_datapath #(
    parameter int MAX_FRACTION_DIGITS = rdc_pkg::MAX_FRACTION_DIGITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdc_pkg::t_ctrl    i_ctrl,
    input  rdc_pkg::t_in      i_item,
    output rdc_pkg::t_status  o_status,
    output logic              o_strobe,
    output rdc_pkg::t_out     o_result
);

    localparam int FC_W  = (MAX_FRACTION_DIGITS > 1) ? $clog2(MAX_FRACTION_DIGITS) : 1;
    localparam int PROD_W = rdc_pkg::FRACTION_BITS + rdc_pkg::BASE_BITS;

    logic [rdc_pkg::DIV_BITS-1:0]      r_q, n_q;
    logic [rdc_pkg::DIGIT_BITS-1:0]    r_rem, n_rem;
    logic [rdc_pkg::BASE_BITS-1:0]     r_b, n_b;
    logic [rdc_pkg::FRACTION_BITS-1:0] r_f, n_f;
    logic [rdc_pkg::DEPTH_W-1:0]       r_depth, n_depth;
    logic [rdc_pkg::CHUNK_CNT_W-1:0]   r_chunk, n_chunk;
    logic [FC_W-1:0]                   r_fcnt, n_fcnt;
    logic                              r_strobe, n_strobe;
    rdc_pkg::t_out                     r_out, n_out;

    logic [rdc_pkg::DIGIT_BITS-1:0]    mem [rdc_pkg::INT_BITS];
    logic [rdc_pkg::DIGIT_BITS-1:0]    r_rd;
    logic [rdc_pkg::DEPTH_W-1:0]       rd_addr;

    logic [rdc_pkg::DIV_BITS-1:0]      div_q;
    logic [rdc_pkg::DIGIT_BITS-1:0]    div_rem;
    logic [PROD_W-1:0]                 prod;
    logic [rdc_pkg::DIGIT_BITS-1:0]    frac_digit;
    logic [rdc_pkg::FRACTION_BITS-1:0] frac_next;
    logic                              fcnt_last;
    logic [rdc_pkg::BASE_BITS-1:0]     base_clamped;

    // one chunk of restoring division, a quotient bit per step
    always_comb begin
        logic [rdc_pkg::BASE_BITS-1:0] rem5;
        div_q   = r_q;
        div_rem = r_rem;
        for (int k = 0; k < rdc_pkg::CHUNK_BITS; k++) begin
            rem5  = {div_rem, div_q[rdc_pkg::DIV_BITS-1]};
            div_q = {div_q[rdc_pkg::DIV_BITS-2:0], 1'b0};
            if (rem5 >= r_b) begin
                rem5     = rem5 - r_b;
                div_q[0] = 1'b1;
            end
            div_rem = rem5[rdc_pkg::DIGIT_BITS-1:0];
        end
    end

    assign prod = {{rdc_pkg::BASE_BITS{1'b0}}, r_f} * {{rdc_pkg::FRACTION_BITS{1'b0}}, r_b};
    assign frac_digit = prod[rdc_pkg::FRACTION_BITS +: rdc_pkg::DIGIT_BITS];
    assign frac_next  = prod[rdc_pkg::FRACTION_BITS-1:0];
    assign fcnt_last  = (r_fcnt == FC_W'(MAX_FRACTION_DIGITS - 1));

    always_comb begin
        if (i_item.base < rdc_pkg::BASE_MIN) begin
            base_clamped = rdc_pkg::BASE_MIN;
        end else if (i_item.base > rdc_pkg::BASE_MAX) begin
            base_clamped = rdc_pkg::BASE_MAX;
        end else begin
            base_clamped = i_item.base;
        end
    end

    assign o_status.chunk_last = (r_chunk == rdc_pkg::CHUNK_CNT_W'(rdc_pkg::CHUNKS - 1));
    assign o_status.q_zero     = (r_q == '0);
    assign o_status.depth_one  = (r_depth == rdc_pkg::DEPTH_W'(1));
    assign o_status.frac_end   = (r_f == '0) || (frac_next == '0) || fcnt_last;

    always_comb begin
        n_q      = r_q;
        n_rem    = r_rem;
        n_b      = r_b;
        n_f      = r_f;
        n_depth  = r_depth;
        n_chunk  = r_chunk;
        n_fcnt   = r_fcnt;
        n_strobe = 1'b0;
        n_out    = r_out;
        unique case (i_ctrl.op)
            rdc_pkg::OP_LOAD: begin
                n_q     = rdc_pkg::DIV_BITS'(i_item.integer_part);
                n_rem   = '0;
                n_b     = base_clamped;
                n_f     = i_item.fraction;
                n_depth = '0;
                n_chunk = '0;
                n_fcnt  = '0;
            end
            rdc_pkg::OP_DIV: begin
                n_q     = div_q;
                n_rem   = div_rem;
                n_chunk = r_chunk + 1'b1;
            end
            rdc_pkg::OP_PUSH: begin
                n_rem   = '0;
                n_chunk = '0;
                n_depth = r_depth + 1'b1;
            end
            rdc_pkg::OP_NOP: begin
            end
            rdc_pkg::OP_EMIT_INT: begin
                n_depth           = r_depth - 1'b1;
                n_strobe          = 1'b1;
                n_out.digit_value = r_rd;
                n_out.digit_char  = rdc_pkg::char_of(r_rd);
                n_out.is_fraction = 1'b0;
                n_out.last        = o_status.depth_one && (r_f == '0);
            end
            rdc_pkg::OP_EMIT_FRAC: begin
                // nothing left to emit once the fraction is zero
                if (r_f != '0) begin
                    n_strobe          = 1'b1;
                    n_out.digit_value = frac_digit;
                    n_out.digit_char  = rdc_pkg::char_of(frac_digit);
                    n_out.is_fraction = 1'b1;
                    n_out.last        = o_status.frac_end;
                    n_f               = frac_next;
                    n_fcnt            = r_fcnt + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // read address follows the next depth so the top entry is ready on the emit step
    assign rd_addr = n_depth - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.op == rdc_pkg::OP_PUSH) begin
            mem[r_depth] <= r_rem;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_chunk  <= '0;
            r_fcnt   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_depth  <= n_depth;
            r_chunk  <= n_chunk;
            r_fcnt   <= n_fcnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        r_b   <= n_b;
        r_f   <= n_f;
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

FILE: src/rdc_checker.sv
// port-level checks on the radix digit converter, bound to the top level
// depends on rdc_pkg and radix_digit_converter_core_macros.svh
`include "radix_digit_converter_core_macros.svh"

module rdc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input rdc_pkg::t_out o_result,
    input logic          o_strobe
);

    logic [rdc_pkg::CHAR_BITS-1:0] exp_char;

    assign exp_char = rdc_pkg::char_of(o_result.digit_value);

    `RDC_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy,
        "accepted item did not raise busy")
    `RDC_ASSERT_NOW(a_char_matches, i_clk, i_rst_n, o_strobe, o_result.digit_char == exp_char,
        "digit character does not match digit value")
    `RDC_ASSERT_NOW(a_busy_mid_item, i_clk, i_rst_n, o_strobe && !o_result.last, busy,
        "block went idle before the last digit")
    `RDC_ASSERT_NEXT(a_frac_order, i_clk, i_rst_n, o_strobe && o_result.is_fraction,
        !o_strobe || o_result.is_fraction, "whole-part digit after a fraction digit")
    `RDC_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_strobe && o_result.last, !o_strobe,
        "digit transfer right after the last digit")

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_result (o_result),
    .o_strobe (o_strobe)
);
